// ===== rtl/core/dcg_pkg.sv =====
// Shared types and constants for the dual edge coincidence guard.
package dcg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef logic signed [DataW-1:0] sample_t;
  typedef logic [DataW-1:0] tick_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_A_TRIG = 2'd0,
    CFG_B_TRIG = 2'd1,
    CFG_WINDOW = 2'd2
  } cfg_reg_e;

  localparam sample_t ResetATrig = sample_t'(0);
  localparam sample_t ResetBTrig = sample_t'(1);
  localparam tick_t ResetWindow = tick_t'(1000);

  // per-channel view after the edge check, before timeout and coincidence
  typedef struct packed {
    logic  latched;
    tick_t stamp;
  } chan_stat_t;

  // configuration as seen by the datapath
  typedef struct packed {
    sample_t a_trig;
    sample_t b_trig;
    tick_t   window;
  } cfg_t;

endpackage

// ===== rtl/core/dcg_cfg.sv =====
// Configuration register file for the dual edge coincidence guard.
module dcg_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dcg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dcg_pkg::DataW-1:0]    cfg_data_i,
  output dcg_pkg::cfg_t                cfg_o
);

  dcg_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (dcg_pkg::cfg_reg_e'(cfg_index_i))
        dcg_pkg::CFG_A_TRIG: cfg_d.a_trig = dcg_pkg::sample_t'(cfg_data_i);
        dcg_pkg::CFG_B_TRIG: cfg_d.b_trig = dcg_pkg::sample_t'(cfg_data_i);
        dcg_pkg::CFG_WINDOW: cfg_d.window = dcg_pkg::tick_t'(cfg_data_i);
        default: cfg_d = cfg_q; // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_trig <= dcg_pkg::ResetATrig;
      cfg_q.b_trig <= dcg_pkg::ResetBTrig;
      cfg_q.window <= dcg_pkg::ResetWindow;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/dcg_chan.sv =====
// One channel: baseline capture, edge detection into the trigger value and latch.
module dcg_chan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 present_i,
  input  dcg_pkg::sample_t     sample_i,
  input  dcg_pkg::sample_t     trig_i,
  input  dcg_pkg::tick_t       now_i,
  input  logic                 drop_i,
  output dcg_pkg::chan_stat_t  stat_o
);

  logic             have_base_q, have_base_d;
  dcg_pkg::sample_t previous_q, previous_d;
  logic             latched_q;
  dcg_pkg::tick_t   stamp_q;
  logic             edge_hit;

  // edge only after baseline, from a non-trigger value, and not already latched
  assign edge_hit = present_i && have_base_q && (previous_q != trig_i)
                    && (sample_i == trig_i) && !latched_q;

  always_comb begin
    have_base_d = have_base_q;
    previous_d  = previous_q;
    if (present_i) begin
      have_base_d = 1'b1;
      previous_d  = sample_i;
    end
    stat_o.latched = latched_q || edge_hit;
    stat_o.stamp   = edge_hit ? now_i : stamp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_base_q <= 1'b0;
      previous_q  <= '0;
      latched_q   <= 1'b0;
      stamp_q     <= '0;
    end else if (en_i) begin
      have_base_q <= have_base_d;
      previous_q  <= previous_d;
      latched_q   <= stat_o.latched && !drop_i;
      stamp_q     <= stat_o.stamp;
    end
  end

endmodule

// ===== rtl/core/dual_edge_coincidence_guard_unit.sv =====
// Top level of the dual edge coincidence guard.
//
// Input channel (in_valid_i / in_stall_o) takes one evaluation tick per
// request: present flag and sample for channels A and B plus a timestamp.
// Output channel (out_valid_o / out_stall_i) returns one joint_trigger_o
// per request, in order.
// Configuration: cfg_valid_i / cfg_ready_o writes register cfg_index_i
// (0 = A trigger, 1 = B trigger, 2 = window in ticks); ready is always high.
// Write only while no request is in flight.
// A request passes through the input register, then the result register,
// which drives out_valid_o. Throughput: one request per cycle while the
// output is not stalled, set by the single edge/latch/timeout evaluation
// between those two registers.
// A stalled result holds; one further request is taken into the input
// register meanwhile, after which in_stall_o follows out_stall_i.
// Reset clears all channel state and loads the default trigger values and
// window; no request is accepted until rst_ni is released.
module dual_edge_coincidence_guard_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dcg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dcg_pkg::DataW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         a_present_i,
  input  logic signed [dcg_pkg::DataW-1:0] a_sample_i,
  input  logic                         b_present_i,
  input  logic signed [dcg_pkg::DataW-1:0] b_sample_i,
  input  logic [dcg_pkg::DataW-1:0]    time_now_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         joint_trigger_o
);

  dcg_pkg::cfg_t cfg;

  // input register
  logic             s1_valid_q;
  logic             a_present_q, b_present_q;
  dcg_pkg::sample_t a_sample_q, b_sample_q;
  dcg_pkg::tick_t   now_q;

  // result register
  logic out_valid_q;
  logic trig_q;

  logic s2_ready, s1_adv, in_take;
  dcg_pkg::chan_stat_t a_stat, b_stat;
  logic a_old, b_old, both, a_drop, b_drop;

  dcg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_present_q <= a_present_i;
      a_sample_q  <= a_sample_i;
      b_present_q <= b_present_i;
      b_sample_q  <= b_sample_i;
      now_q       <= time_now_i;
    end
  end

  dcg_chan u_chan_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (s1_adv),
    .present_i (a_present_q),
    .sample_i  (a_sample_q),
    .trig_i    (cfg.a_trig),
    .now_i     (now_q),
    .drop_i    (a_drop),
    .stat_o    (a_stat)
  );

  dcg_chan u_chan_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (s1_adv),
    .present_i (b_present_q),
    .sample_i  (b_sample_q),
    .trig_i    (cfg.b_trig),
    .now_i     (now_q),
    .drop_i    (b_drop),
    .stat_o    (b_stat)
  );

  // wrapping age, strictly greater than window; window of zero never expires
  assign a_old  = (cfg.window != '0) && ((now_q - a_stat.stamp) > cfg.window);
  assign b_old  = (cfg.window != '0) && ((now_q - b_stat.stamp) > cfg.window);
  assign both   = a_stat.latched && b_stat.latched;
  assign a_drop = both || (a_stat.latched && !b_stat.latched && a_old);
  assign b_drop = both || (b_stat.latched && !a_stat.latched && b_old);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      trig_q <= both;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign joint_trigger_o = trig_q;

endmodule

// ===== rtl/core/dcg_checker.sv =====
// Port-level checks for the dual edge coincidence guard, bound to the top level.
module dcg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         joint_trigger_o
);

  // a stalled result stays and keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(joint_trigger_o)))
    else $error("stalled result changed");

  // with no result pending the block always takes a request
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // both stages full: backpressure tracks the output stall
  a_stall_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && in_stall_o) |=> (in_stall_o == out_stall_i))
    else $error("input stall out of step with output stall");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind dual_edge_coincidence_guard_unit dcg_checker u_dcg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .joint_trigger_o (joint_trigger_o)
);
